// ----- rtl/dstp_pkg.sv -----
// shared types, constants and palette for the scan-out timing and palette unit
`default_nettype none

package dstp_pkg;

  localparam int unsigned ADDR_BITS_DEF    = 18;
  localparam int unsigned COUNTER_BITS_DEF = 12;

  localparam int unsigned H_ACT_W  = 12;
  localparam int unsigned H_PORCH_W = 8;
  localparam int unsigned V_ACT_W  = 12;
  localparam int unsigned V_PORCH_W = 6;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 12;

  localparam int unsigned FB_W        = 8;
  localparam int unsigned NIB_W       = 4;
  localparam int unsigned RGB_W       = 15;
  localparam int unsigned COLOR24_W   = 24;
  localparam int unsigned FETCH_W     = 18;
  localparam int unsigned IN_TDATA_W  = 8;
  localparam int unsigned OUT_FIELDS_W = 3 + RGB_W + FETCH_W;
  localparam int unsigned OUT_TDATA_W = ((OUT_FIELDS_W + 7) / 8) * 8;

  localparam logic [H_ACT_W-1:0]   H_ACTIVE_RST = H_ACT_W'(640);
  localparam logic [H_PORCH_W-1:0] H_FRONT_RST  = H_PORCH_W'(16);
  localparam logic [H_PORCH_W-1:0] H_SYNC_RST   = H_PORCH_W'(64);
  localparam logic [H_PORCH_W-1:0] H_BACK_RST   = H_PORCH_W'(120);
  localparam logic [V_ACT_W-1:0]   V_ACTIVE_RST = V_ACT_W'(480);
  localparam logic [V_PORCH_W-1:0] V_FRONT_RST  = V_PORCH_W'(1);
  localparam logic [V_PORCH_W-1:0] V_SYNC_RST   = V_PORCH_W'(3);
  localparam logic [V_PORCH_W-1:0] V_BACK_RST   = V_PORCH_W'(16);

  localparam int unsigned LINE_RST = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_H_ACTIVE = 3'd0,
    CFG_H_FRONT  = 3'd1,
    CFG_H_SYNC   = 3'd2,
    CFG_H_BACK   = 3'd3,
    CFG_V_ACTIVE = 3'd4,
    CFG_V_FRONT  = 3'd5,
    CFG_V_SYNC   = 3'd6,
    CFG_V_BACK   = 3'd7
  } cfg_idx_e;

  typedef struct packed {
    logic [H_ACT_W-1:0]   h_active;
    logic [H_PORCH_W-1:0] h_front;
    logic [H_PORCH_W-1:0] h_sync;
    logic [H_PORCH_W-1:0] h_back;
    logic [V_ACT_W-1:0]   v_active;
    logic [V_PORCH_W-1:0] v_front;
    logic [V_PORCH_W-1:0] v_sync;
    logic [V_PORCH_W-1:0] v_back;
  } cfg_t;

  // per-pixel decode handed from the timing stage to the palette stage
  typedef struct packed {
    logic            hs;
    logic            vs;
    logic            de;
    logic            fs;
    logic            hi_nib;
    logic [FB_W-1:0] fb_byte;
  } pix_t;

  localparam logic [COLOR24_W-1:0] PALETTE24 [16] = '{
    24'h000080, 24'hFF0000, 24'h00FF00, 24'h0000FF,
    24'h00FFFF, 24'hFF00FF, 24'hFFFF00, 24'hFFFFFF,
    24'h000000, 24'h7F0000, 24'h007F00, 24'h00007F,
    24'h007F7F, 24'h7F007F, 24'h7F7F00, 24'h7F7F7F
  };

  function automatic logic [RGB_W-1:0] to_rgb555(input logic [COLOR24_W-1:0] c);
    return {c[23:19], c[15:11], c[7:3]};
  endfunction

endpackage

`default_nettype wire

// ----- rtl/dvi_scanout_timing_palette_unit.sv -----
// top level of the scan-out timing generator with 16-color palette
// a request is registered in the timing stage, then in the palette output register
// throughput: one request per cycle while m_axis_tready is high, set by the two-register pipeline with ready chaining
// reset: pixel counter 0, line counter 2, fetch address 0, timing registers at 640x480
// reset: both pipeline stages empty, no clearing pass
`default_nettype none

module dvi_scanout_timing_palette_unit #(
  parameter int unsigned ADDR_BITS    = dstp_pkg::ADDR_BITS_DEF,
  parameter int unsigned COUNTER_BITS = dstp_pkg::COUNTER_BITS_DEF
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             cfg_we_i,
  input  wire logic [dstp_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  wire logic [dstp_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  input  wire logic                             s_axis_tvalid,
  output logic                                  s_axis_tready,
  // fb_byte
  input  wire logic [dstp_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
  output logic                                  m_axis_tvalid,
  input  wire logic                             m_axis_tready,
  // hsync_level, vsync_level, data_enable, pixel_rgb555, fetch_address, zero pad
  output logic [dstp_pkg::OUT_TDATA_W-1:0]      m_axis_tdata,
  // frame_start
  output logic                                  m_axis_tuser
);
  import dstp_pkg::*;

  cfg_t                 cfg;
  pix_t                 pix;
  logic                 pix_valid, pix_ready;
  logic [ADDR_BITS-1:0] addr;

  dstp_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  dstp_timing #(
    .ADDR_BITS    (ADDR_BITS),
    .COUNTER_BITS (COUNTER_BITS)
  ) u_timing (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .fb_byte_i   (s_axis_tdata[FB_W-1:0]),
    .pix_valid_o (pix_valid),
    .pix_ready_i (pix_ready),
    .pix_o       (pix),
    .addr_o      (addr)
  );

  dstp_palette #(
    .ADDR_BITS (ADDR_BITS)
  ) u_palette (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pix_valid_i (pix_valid),
    .pix_ready_o (pix_ready),
    .pix_i       (pix),
    .addr_i      (addr),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (m_axis_tdata),
    .out_fs_o    (m_axis_tuser)
  );

endmodule

`default_nettype wire

// ----- rtl/dstp_cfg_regs.sv -----
// timing configuration registers with write port
`default_nettype none

module dstp_cfg_regs (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             cfg_we_i,
  input  wire logic [dstp_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  wire logic [dstp_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  output dstp_pkg::cfg_t                        cfg_o
);
  import dstp_pkg::*;

  cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.h_active <= H_ACTIVE_RST;
      cfg_q.h_front  <= H_FRONT_RST;
      cfg_q.h_sync   <= H_SYNC_RST;
      cfg_q.h_back   <= H_BACK_RST;
      cfg_q.v_active <= V_ACTIVE_RST;
      cfg_q.v_front  <= V_FRONT_RST;
      cfg_q.v_sync   <= V_SYNC_RST;
      cfg_q.v_back   <= V_BACK_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_H_ACTIVE: cfg_q.h_active <= cfg_data_i[H_ACT_W-1:0];
        CFG_H_FRONT:  cfg_q.h_front  <= cfg_data_i[H_PORCH_W-1:0];
        CFG_H_SYNC:   cfg_q.h_sync   <= cfg_data_i[H_PORCH_W-1:0];
        CFG_H_BACK:   cfg_q.h_back   <= cfg_data_i[H_PORCH_W-1:0];
        CFG_V_ACTIVE: cfg_q.v_active <= cfg_data_i[V_ACT_W-1:0];
        CFG_V_FRONT:  cfg_q.v_front  <= cfg_data_i[V_PORCH_W-1:0];
        CFG_V_SYNC:   cfg_q.v_sync   <= cfg_data_i[V_PORCH_W-1:0];
        CFG_V_BACK:   cfg_q.v_back   <= cfg_data_i[V_PORCH_W-1:0];
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

// ----- rtl/dstp_timing.sv -----
// pixel and line counters, sync and active decode, fetch address, input stage
`default_nettype none

module dstp_timing #(
  parameter int unsigned ADDR_BITS    = dstp_pkg::ADDR_BITS_DEF,
  parameter int unsigned COUNTER_BITS = dstp_pkg::COUNTER_BITS_DEF
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  dstp_pkg::cfg_t                    cfg_i,
  input  wire logic                         in_valid_i,
  output logic                              in_ready_o,
  input  wire logic [dstp_pkg::FB_W-1:0]    fb_byte_i,
  output logic                              pix_valid_o,
  input  wire logic                         pix_ready_i,
  output dstp_pkg::pix_t                    pix_o,
  output logic [ADDR_BITS-1:0]              addr_o
);
  import dstp_pkg::*;

  localparam int unsigned CMP_W = ((COUNTER_BITS > 13) ? COUNTER_BITS : 13) + 1;

  logic [COUNTER_BITS-1:0] pix_cnt_q, pix_cnt_d;
  logic [COUNTER_BITS-1:0] line_cnt_q, line_cnt_d;
  logic [ADDR_BITS-1:0]    addr_q, addr_d;
  logic                    valid_q;
  pix_t                    pix_q, pix_d;

  logic [CMP_W-1:0] pe, le;
  logic [CMP_W-1:0] h_fs, h_bl, h_tot, v_fs, v_bl, v_tot;
  logic             h_act, v_act, de, odd, p_wrap, l_wrap, accept;
  logic [ADDR_BITS-1:0] addr_inc;

  assign in_ready_o = !valid_q || pix_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    pe    = CMP_W'(pix_cnt_q);
    le    = CMP_W'(line_cnt_q);
    h_fs  = CMP_W'(cfg_i.h_front) + CMP_W'(cfg_i.h_sync);
    h_bl  = h_fs + CMP_W'(cfg_i.h_back);
    h_tot = h_bl + CMP_W'(cfg_i.h_active);
    v_fs  = CMP_W'(cfg_i.v_front) + CMP_W'(cfg_i.v_sync);
    v_bl  = v_fs + CMP_W'(cfg_i.v_back);
    v_tot = v_bl + CMP_W'(cfg_i.v_active);

    h_act = (pe >= h_bl) && (pe < h_tot);
    v_act = (le >= v_bl) && (le < v_tot);
    de    = h_act && v_act;
    odd   = pix_cnt_q[0] ^ h_bl[0];

    pix_d.hs      = !((pe >= CMP_W'(cfg_i.h_front)) && (pe < h_fs));
    pix_d.vs      = !((le >= CMP_W'(cfg_i.v_front)) && (le < v_fs));
    pix_d.de      = de;
    pix_d.fs      = (pix_cnt_q == '0) && (line_cnt_q == '0);
    pix_d.hi_nib  = odd;
    pix_d.fb_byte = fb_byte_i;

    p_wrap = ((pe + CMP_W'(1)) >= h_tot) || (pix_cnt_q == '1);
    l_wrap = ((le + CMP_W'(1)) >= v_tot) || (line_cnt_q == '1);

    addr_inc = (de && odd) ? addr_q + ADDR_BITS'(1) : addr_q;

    pix_cnt_d  = pix_cnt_q + COUNTER_BITS'(1);
    line_cnt_d = line_cnt_q;
    addr_d     = addr_inc;
    if (p_wrap) begin
      pix_cnt_d = '0;
      if (l_wrap) begin
        line_cnt_d = '0;
        addr_d     = '0;
      end else begin
        line_cnt_d = line_cnt_q + COUNTER_BITS'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pix_cnt_q  <= '0;
      line_cnt_q <= COUNTER_BITS'(LINE_RST);
      addr_q     <= '0;
      valid_q    <= 1'b0;
    end else begin
      if (accept) begin
        pix_cnt_q  <= pix_cnt_d;
        line_cnt_q <= line_cnt_d;
        addr_q     <= addr_d;
      end
      if (in_ready_o) begin
        valid_q <= in_valid_i;
      end
    end
  end

  // address of the request reflects the state after this pixel
  logic [ADDR_BITS-1:0] addr_out_q;

  always_ff @(posedge clk_i) begin
    if (accept) begin
      pix_q      <= pix_d;
      addr_out_q <= addr_d;
    end
  end

  assign pix_valid_o = valid_q;
  assign pix_o       = pix_q;
  assign addr_o      = addr_out_q;

endmodule

`default_nettype wire

// ----- rtl/dstp_palette.sv -----
// nibble select, palette lookup and output register
`default_nettype none

module dstp_palette #(
  parameter int unsigned ADDR_BITS = dstp_pkg::ADDR_BITS_DEF
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             pix_valid_i,
  output logic                                  pix_ready_o,
  input  dstp_pkg::pix_t                        pix_i,
  input  wire logic [ADDR_BITS-1:0]             addr_i,
  output logic                                  out_valid_o,
  input  wire logic                             out_ready_i,
  output logic [dstp_pkg::OUT_TDATA_W-1:0]      out_data_o,
  output logic                                  out_fs_o
);
  import dstp_pkg::*;

  localparam int unsigned FW = (ADDR_BITS < FETCH_W) ? ADDR_BITS : FETCH_W;

  logic                   valid_q;
  logic [NIB_W-1:0]       nib;
  logic [RGB_W-1:0]       rgb_d;
  logic [FETCH_W-1:0]     fetch_d;
  logic [OUT_TDATA_W-1:0] data_q, data_d;
  logic                   fs_q;

  assign pix_ready_o = !valid_q || out_ready_i;

  always_comb begin
    nib     = pix_i.hi_nib ? pix_i.fb_byte[7:4] : pix_i.fb_byte[3:0];
    rgb_d   = pix_i.de ? to_rgb555(PALETTE24[nib]) : '0;
    fetch_d = FETCH_W'(addr_i[FW-1:0]);
    data_d  = OUT_TDATA_W'({fetch_d, rgb_d, pix_i.de, pix_i.vs, pix_i.hs});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (pix_ready_o) begin
      valid_q <= pix_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pix_ready_o && pix_valid_i) begin
      data_q <= data_d;
      fs_q   <= pix_i.fs;
    end
  end

  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;
  assign out_fs_o    = fs_q;

endmodule

`default_nettype wire

// ----- rtl/dstp_checker.sv -----
// port-level checks for the scan-out timing unit and their bind
`default_nettype none

module dstp_checker (
  input wire logic                             clk_i,
  input wire logic                             rst_ni,
  input wire logic                             s_axis_tvalid,
  input wire logic                             s_axis_tready,
  input wire logic                             m_axis_tvalid,
  input wire logic                             m_axis_tready,
  input wire logic [dstp_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);
  import dstp_pkg::*;

  logic [1:0] inflight_q, inflight_d;
  logic       in_acc, out_acc;

  assign in_acc  = s_axis_tvalid && s_axis_tready;
  assign out_acc = m_axis_tvalid && m_axis_tready;

  always_comb begin
    inflight_d = inflight_q;
    if (in_acc && !out_acc) begin
      inflight_d = inflight_q + 2'd1;
    end else if (!in_acc && out_acc) begin
      inflight_d = inflight_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inflight_q <= '0;
    end else begin
      inflight_q <= inflight_d;
    end
  end

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  a_blank_black: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tdata[2] |-> m_axis_tdata[17:3] == '0)
    else $error("color outside active video");

  a_no_phantom: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> inflight_q != 2'd0)
    else $error("result without a request");

  a_depth: assert property (@(posedge clk_i) disable iff (!rst_ni)
    inflight_q != 2'd3)
    else $error("more requests in flight than pipeline stages");

endmodule

bind dvi_scanout_timing_palette_unit dstp_checker u_dstp_checker (.*);

`default_nettype wire
